FILE: design/spq_pkg.sv
package spq_pkg;

  // default sizing
  localparam int unsigned SPQ_DEPTH       = 256;
  localparam int unsigned SPQ_PRIO_BITS   = 16;
  localparam int unsigned SPQ_HANDLE_BITS = 9;

  // fixed field widths of the request and result
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned HANDLE_W = 9;
  localparam int unsigned OCC_W    = 9;
  localparam int unsigned STATUS_W = 2;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [PRIO_W-1:0]   prio_in;
    logic [KEY_W-1:0]    key_in;
    logic [HANDLE_W-1:0] handle_in;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [PRIO_W-1:0]   prio_out;
    logic [KEY_W-1:0]    key_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [OCC_W-1:0]    occupancy;
  } out_res_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: design/spq_cell.sv
module spq_cell #(
  parameter int unsigned PRIO_BITS   = 16,
  parameter int unsigned HANDLE_BITS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::cell_ctrl_t           ctrl_i,
  input  logic [PRIO_BITS-1:0]          new_prio_i,
  input  logic [spq_pkg::KEY_W-1:0]     new_key_i,
  input  logic [HANDLE_BITS-1:0]        new_handle_i,
  // neighbour nearer the tail (lower index)
  input  logic                          lo_before_i,
  input  logic                          lo_valid_i,
  input  logic [PRIO_BITS-1:0]          lo_prio_i,
  input  logic [spq_pkg::KEY_W-1:0]     lo_key_i,
  input  logic [HANDLE_BITS-1:0]        lo_handle_i,
  // neighbour nearer the head (higher index)
  input  logic                          hi_valid_i,
  input  logic [PRIO_BITS-1:0]          hi_prio_i,
  input  logic [spq_pkg::KEY_W-1:0]     hi_key_i,
  input  logic [HANDLE_BITS-1:0]        hi_handle_i,
  output logic                          before_o,
  output logic                          valid_o,
  output logic [PRIO_BITS-1:0]          prio_o,
  output logic [spq_pkg::KEY_W-1:0]     key_o,
  output logic [HANDLE_BITS-1:0]        handle_o
);
  import spq_pkg::*;

  logic                   valid_q, valid_d;
  logic [PRIO_BITS-1:0]   prio_q, prio_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   ahead;

  // new entry sorts ahead of the one held here
  assign ahead = valid_q && ((new_prio_i > prio_q) ||
                 ((new_prio_i == prio_q) && (new_key_i <= key_q)));

  always_comb begin
    valid_d  = valid_q;
    prio_d   = prio_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.ins && !ahead) begin
      if (lo_before_i) begin
        valid_d  = 1'b1;
        prio_d   = new_prio_i;
        key_d    = new_key_i;
        handle_d = new_handle_i;
      end else begin
        valid_d  = lo_valid_i;
        prio_d   = lo_prio_i;
        key_d    = lo_key_i;
        handle_d = lo_handle_i;
      end
    end else if (ctrl_i.rem) begin
      valid_d  = hi_valid_i;
      prio_d   = hi_prio_i;
      key_d    = hi_key_i;
      handle_d = hi_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q   <= prio_d;
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign before_o = ahead;
  assign valid_o  = valid_q;
  assign prio_o   = prio_q;
  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

FILE: design/sorted_priority_queue.sv
// Bounded priority queue built as a row of DEPTH compare-and-shift cells.
// Cell 0 always holds the entry a remove returns: the lowest priority, and
// among equal priorities the highest key; priority rises (and key falls)
// towards the higher cells. An insert request is broadcast to every cell,
// each cell compares it with its own entry in parallel, and together
// the cells on the tail side keep their entries, the boundary cell
// takes the new one and the cells beyond move up by one. A remove moves
// every cell down by one and returns the old cell 0. One request is taken
// per clock cycle; its result appears in the output register on the next
// cycle, and the next request is taken while that result waits, as long as
// the result is accepted in the same cycle. The rate is set by the
// compare and shift across the row of cells. An insert into a
// full queue is dropped with status full; a remove from an empty queue
// reports status empty. Result fields that carry no entry read as zero.
module sorted_priority_queue #(
  parameter int unsigned DEPTH       = spq_pkg::SPQ_DEPTH,
  parameter int unsigned PRIO_BITS   = spq_pkg::SPQ_PRIO_BITS,
  parameter int unsigned HANDLE_BITS = spq_pkg::SPQ_HANDLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::out_res_t out_res_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // per-cell views, indexed by position in the row
  logic                   cell_before [DEPTH];
  logic                   cell_valid  [DEPTH];
  logic [PRIO_BITS-1:0]   cell_prio   [DEPTH];
  logic [KEY_W-1:0]       cell_key    [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];

  logic                   accept;
  logic                   full, empty;
  cell_ctrl_t             ctrl;
  logic [PRIO_BITS-1:0]   new_prio;
  logic [HANDLE_BITS-1:0] new_handle;

  logic [CNT_W-1:0]       count_q, count_d;
  logic                   res_valid_q;
  out_res_t               res_q, res_d;

  // a request goes in whenever the output register is free or draining
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // the row is full when the top cell holds an entry, empty when cell 0 does not
  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  // bits beyond the stored widths are ignored
  assign new_prio   = PRIO_BITS'(in_req_i.prio_in);
  assign new_handle = HANDLE_BITS'(in_req_i.handle_in);

  always_comb begin
    ctrl.ins = accept && (in_req_i.req_type == REQ_INSERT) && !full;
    ctrl.rem = accept && (in_req_i.req_type == REQ_REMOVE) && !empty;
  end

  // the row of cells: each sees its two neighbours and the broadcast request
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                   lo_before, lo_valid, hi_valid;
    logic [PRIO_BITS-1:0]   lo_prio, hi_prio;
    logic [KEY_W-1:0]       lo_key, hi_key;
    logic [HANDLE_BITS-1:0] lo_handle, hi_handle;

    if (g == 0) begin : g_tail
      // below the tail the new entry always sorts ahead
      assign lo_before = 1'b1;
      assign lo_valid  = 1'b0;
      assign lo_prio   = '0;
      assign lo_key    = '0;
      assign lo_handle = '0;
    end else begin : g_lo
      assign lo_before = cell_before[g-1];
      assign lo_valid  = cell_valid[g-1];
      assign lo_prio   = cell_prio[g-1];
      assign lo_key    = cell_key[g-1];
      assign lo_handle = cell_handle[g-1];
    end

    if (g == DEPTH - 1) begin : g_head
      // nothing beyond the head, so a remove empties the top cell
      assign hi_valid  = 1'b0;
      assign hi_prio   = '0;
      assign hi_key    = '0;
      assign hi_handle = '0;
    end else begin : g_hi
      assign hi_valid  = cell_valid[g+1];
      assign hi_prio   = cell_prio[g+1];
      assign hi_key    = cell_key[g+1];
      assign hi_handle = cell_handle[g+1];
    end

    spq_cell #(
      .PRIO_BITS  (PRIO_BITS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_prio_i  (new_prio),
      .new_key_i   (in_req_i.key_in),
      .new_handle_i(new_handle),
      .lo_before_i (lo_before),
      .lo_valid_i  (lo_valid),
      .lo_prio_i   (lo_prio),
      .lo_key_i    (lo_key),
      .lo_handle_i (lo_handle),
      .hi_valid_i  (hi_valid),
      .hi_prio_i   (hi_prio),
      .hi_key_i    (hi_key),
      .hi_handle_i (hi_handle),
      .before_o    (cell_before[g]),
      .valid_o     (cell_valid[g]),
      .prio_o      (cell_prio[g]),
      .key_o       (cell_key[g]),
      .handle_o    (cell_handle[g])
    );
  end

  // occupancy count, kept alongside the cell valid bits for reporting
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result for the request taken this cycle
  always_comb begin
    res_d            = '0;
    res_d.status     = ST_OK;
    res_d.occupancy  = OCC_W'(count_d);
    case (in_req_i.req_type)
      REQ_INSERT: begin
        if (full) begin
          res_d.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.out_valid  = 1'b1;
          res_d.prio_out   = PRIO_W'(cell_prio[0]);
          res_d.key_out    = cell_key[0];
          res_d.handle_out = HANDLE_W'(cell_handle[0]);
        end
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule
